// ===== rtl/core/bitmap_rle_run_decoder_core_assert.svh =====
// Assertion macros shared by the run decoder RTL.
`ifndef BITMAP_RLE_RUN_DECODER_CORE_ASSERT_SVH
`define BITMAP_RLE_RUN_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define BRLE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define BRLE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/brle_pkg.sv =====
// Shared types and constants of the run-length bitmap decoder.
package brle_pkg;

   // Coordinate width for width, height, column and line (8 to 16).
   localparam int COORD_BITS = 16;
   localparam int WIDE_BITS  = COORD_BITS + 1;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [WIDE_BITS-1:0]  wide_type;

   // Queue between front and back; depth must be a power of two.
   localparam int QUEUE_DEPTH      = 2;
   localparam int QUEUE_PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Result status codes.
   localparam logic [1:0] STATUS_PIXELS = 2'd0;
   localparam logic [1:0] STATUS_DONE   = 2'd1;
   localparam logic [1:0] STATUS_ERROR  = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_TOP_DOWN     = 2'd2;
   localparam logic [1:0] CSR_NIBBLE_MODE  = 2'd3;

   // One classified stream byte.
   typedef struct packed {
      logic [7:0] data;
      logic       is_zero;
      logic       is_one;
      logic       is_two;
   } brle_item_type;

   // A valid-qualified item moving between front, queue and back.
   typedef struct packed {
      logic          valid;
      brle_item_type item;
   } brle_slot_type;

endpackage

// ===== rtl/core/brle_front.sv =====
// Front stage: accepts stream bytes, classifies them and hands them to the queue.
module brle_front import brle_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [7:0]    req_data_byte,
   output brle_slot_type push,
   input  logic          queue_full
);

   logic          valid_ff, valid_in;
   brle_item_type item_ff, item_in;
   logic          advance;

   // The held byte leaves as soon as the queue has room.
   assign advance   = !valid_ff || !queue_full;
   assign req_ready = advance;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (advance) begin
         valid_in        = req_valid;
         item_in.data    = req_data_byte;
         item_in.is_zero = (req_data_byte == 8'd0);
         item_in.is_one  = (req_data_byte == 8'd1);
         item_in.is_two  = (req_data_byte == 8'd2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign push.valid = valid_ff;
   assign push.item  = item_ff;

endmodule

// ===== rtl/core/brle_queue.sv =====
// Short queue that decouples the byte front from the execution back.
module brle_queue import brle_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  brle_slot_type push,
   output logic          full,
   output brle_slot_type head,
   input  logic          pop
);

   `include "bitmap_rle_run_decoder_core_assert.svh"

   brle_item_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_BITS-1:0]   count_ff, count_in;
   logic                          do_push;

   assign full    = (count_ff == QUEUE_COUNT_BITS'(QUEUE_DEPTH));
   assign do_push = push.valid && !full;

   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      case ({do_push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.item;
      end
   end

   `BRLE_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= QUEUE_COUNT_BITS'(QUEUE_DEPTH), "queue count above depth")
   `BRLE_ASSERT_NOW(a_empty_ptrs, count_ff == '0, wr_ptr_ff == rd_ptr_ff, "empty queue with split pointers")

endmodule

// ===== rtl/core/brle_back.sv =====
// Back stage: runs the run-length parse per item and registers the descriptor.
module brle_back import brle_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  brle_slot_type head,
   output logic          pop,
   input  logic          csr_fire,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_wdata,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [1:0]    rsp_status,
   output logic [15:0]   rsp_pixel_row,
   output logic [15:0]   rsp_pixel_column,
   output logic [7:0]    rsp_pixel_count,
   output logic [7:0]    rsp_even_index,
   output logic [7:0]    rsp_odd_index
);

   `include "bitmap_rle_run_decoder_core_assert.svh"

   typedef enum logic [2:0] {
      PH_COUNT,
      PH_SECOND,
      PH_XDELTA,
      PH_YDELTA,
      PH_ABS,
      PH_ERROR
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   coord_type  line_ff, line_in;
   coord_type  column_ff, column_in;
   logic [7:0] left_ff, left_in;
   logic       pad_ff, pad_in;

   coord_type  width_ff, width_in;
   coord_type  height_ff, height_in;
   logic       top_ff, top_in;
   logic       nibble_ff, nibble_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [15:0] rsp_row_ff, rsp_row_in;
   logic [15:0] rsp_col_ff, rsp_col_in;
   logic [7:0] rsp_count_ff, rsp_count_in;
   logic [7:0] rsp_even_ff, rsp_even_in;
   logic [7:0] rsp_odd_ff, rsp_odd_in;

   logic       step, halted;
   logic [7:0] b;
   logic       emit_pix, emit_done, emit_error;
   logic [7:0] pix_n;

   coord_type  room;
   logic [7:0] enc_n;
   wide_type   width_x, sum1, sum2;
   logic [7:0] n2, abs_n, abs_nm1;
   coord_type  b_c, line_dy;
   logic [7:0] take, left_next;
   coord_type  row;

   assign b      = head.item.data;
   assign step   = head.valid && (!rsp_valid_ff || rsp_ready);
   assign pop    = step;
   assign halted = (phase_ff == PH_ERROR) || (line_ff == '0);

   // Datapath terms shared by the parse arms.
   always_comb begin
      room    = (column_ff < width_ff) ? (width_ff - column_ff) : '0;
      enc_n   = (coord_type'(held_ff) < room) ? held_ff : room[7:0];
      width_x = wide_type'(width_ff);
      sum1    = wide_type'(column_ff) + wide_type'(b);
      n2      = b - {7'd0, width_ff[0]};
      sum2    = wide_type'(column_ff) + wide_type'(n2);
      abs_n   = (sum1 > width_x) ? n2 : b;
      abs_nm1 = abs_n - 8'd1;
      b_c     = coord_type'(b);
      line_dy = (b_c < line_ff) ? (line_ff - b_c) : '0;
      if (nibble_ff) begin
         take = (left_ff < 8'd2) ? left_ff : 8'd2;
      end else begin
         take = 8'd1;
      end
      left_next = left_ff - take;
      row = top_ff ? (height_ff - line_ff) : (line_ff - 1'b1);
   end

   always_comb begin
      phase_in   = phase_ff;
      held_in    = held_ff;
      line_in    = line_ff;
      column_in  = column_ff;
      left_in    = left_ff;
      pad_in     = pad_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      top_in     = top_ff;
      nibble_in  = nibble_ff;
      emit_pix   = 1'b0;
      emit_done  = 1'b0;
      emit_error = 1'b0;
      pix_n      = 8'd0;

      if (step && !halted) begin
         unique case (phase_ff)
            PH_COUNT: begin
               held_in  = b;
               phase_in = PH_SECOND;
            end
            PH_SECOND: begin
               phase_in = PH_COUNT;
               if (held_ff != 8'd0) begin
                  // Encoded run, clipped to the line end.
                  pix_n    = enc_n;
                  emit_pix = (enc_n != 8'd0);
               end else if (head.item.is_zero) begin
                  line_in   = line_ff - 1'b1;
                  column_in = '0;
                  emit_done = (line_ff == coord_type'(1));
               end else if (head.item.is_one) begin
                  line_in   = '0;
                  column_in = '0;
                  emit_done = 1'b1;
               end else if (head.item.is_two) begin
                  phase_in = PH_XDELTA;
               end else if ((sum1 > width_x) && (sum2 > width_x)) begin
                  phase_in   = PH_ERROR;
                  emit_error = 1'b1;
               end else begin
                  left_in  = abs_n;
                  pad_in   = nibble_ff ? !abs_nm1[1] : !abs_nm1[0];
                  phase_in = PH_ABS;
               end
            end
            PH_XDELTA: begin
               column_in = (sum1 > width_x) ? width_ff : sum1[COORD_BITS-1:0];
               phase_in  = PH_YDELTA;
            end
            PH_YDELTA: begin
               line_in   = line_dy;
               phase_in  = PH_COUNT;
               emit_done = (line_dy == '0);
            end
            PH_ABS: begin
               if (left_ff == 8'd0) begin
                  // Drop the pad byte.
                  pad_in   = 1'b0;
                  phase_in = PH_COUNT;
               end else begin
                  left_in  = left_next;
                  pix_n    = take;
                  emit_pix = 1'b1;
                  if (left_next == 8'd0 && !pad_ff) begin
                     phase_in = PH_COUNT;
                  end
               end
            end
            default: begin
               phase_in = PH_ERROR;
            end
         endcase
      end

      if (emit_pix) begin
         column_in = column_ff + coord_type'(pix_n);
      end

      if (csr_fire) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_in = csr_wdata[COORD_BITS-1:0];
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = csr_wdata[COORD_BITS-1:0];
               line_in   = csr_wdata[COORD_BITS-1:0];
               column_in = '0;
            end
            CSR_TOP_DOWN: begin
               top_in = csr_wdata[0];
            end
            CSR_NIBBLE_MODE: begin
               nibble_in = csr_wdata[0];
            end
            default: begin
               width_in = width_ff;
            end
         endcase
      end
   end

   // Output register: hold until taken, reload when a step emits.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_even_in   = rsp_even_ff;
      rsp_odd_in    = rsp_odd_ff;
      if (emit_pix || emit_done || emit_error) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = emit_pix ? STATUS_PIXELS : (emit_done ? STATUS_DONE : STATUS_ERROR);
         rsp_row_in    = 16'd0;
         rsp_col_in    = 16'd0;
         rsp_count_in  = 8'd0;
         rsp_even_in   = 8'd0;
         rsp_odd_in    = 8'd0;
         if (emit_pix) begin
            rsp_row_in   = 16'(row);
            rsp_col_in   = 16'(column_ff);
            rsp_count_in = pix_n;
            if (nibble_ff) begin
               rsp_even_in = {4'd0, b[7:4]};
               rsp_odd_in  = {4'd0, b[3:0]};
            end else begin
               rsp_even_in = b;
               rsp_odd_in  = b;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_COUNT;
         held_ff      <= 8'd0;
         line_ff      <= '0;
         column_ff    <= '0;
         left_ff      <= 8'd0;
         pad_ff       <= 1'b0;
         width_ff     <= '0;
         height_ff    <= '0;
         top_ff       <= 1'b0;
         nibble_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         held_ff      <= held_in;
         line_ff      <= line_in;
         column_ff    <= column_in;
         left_ff      <= left_in;
         pad_ff       <= pad_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         top_ff       <= top_in;
         nibble_ff    <= nibble_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_even_ff   <= rsp_even_in;
      rsp_odd_ff    <= rsp_odd_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_pixel_row    = rsp_row_ff;
   assign rsp_pixel_column = rsp_col_ff;
   assign rsp_pixel_count  = rsp_count_ff;
   assign rsp_even_index   = rsp_even_ff;
   assign rsp_odd_index    = rsp_odd_ff;

   `BRLE_ASSERT_NEXT(a_error_sticks, phase_ff == PH_ERROR, phase_ff == PH_ERROR, "error phase left without reset")
   `BRLE_ASSERT_NEXT(a_error_result, emit_error, rsp_valid_ff && rsp_status_ff == STATUS_ERROR && phase_ff == PH_ERROR, "format error not reported")
   `BRLE_ASSERT_NOW(a_status_payload, rsp_valid_ff && rsp_status_ff != STATUS_PIXELS, rsp_count_ff == 8'd0 && rsp_row_ff == 16'd0, "status result with nonzero payload")

endmodule

// ===== rtl/core/bitmap_rle_run_decoder_core.sv =====
// A byte passes the front register and queue; the back registers any descriptor on rsp.
// Throughput: one byte per cycle while rsp_ready holds; the back stage takes one queued
// byte per cycle, limited only by its output register being free or taken.
// Reset: synchronous, active high; clears parse state, registers, queue and output valid.
// Configuration writes are taken in any cycle and apply at once.
module bitmap_rle_run_decoder_core import brle_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_pixel_row,
   output logic [15:0] rsp_pixel_column,
   output logic [7:0]  rsp_pixel_count,
   output logic [7:0]  rsp_even_index,
   output logic [7:0]  rsp_odd_index,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   brle_slot_type push;
   brle_slot_type head;
   logic          queue_full;
   logic          pop;

   assign csr_ready = 1'b1;

   brle_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .push          (push),
      .queue_full    (queue_full)
   );

   brle_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   brle_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .pop              (pop),
      .csr_fire         (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_pixel_row    (rsp_pixel_row),
      .rsp_pixel_column (rsp_pixel_column),
      .rsp_pixel_count  (rsp_pixel_count),
      .rsp_even_index   (rsp_even_index),
      .rsp_odd_index    (rsp_odd_index)
   );

endmodule

// ===== bench/bitmap_rle_run_decoder_core_checker.sv =====
// Escape codes and the descriptor checker for the run decoder bench.
`timescale 1ns / 100ps

package brle_escape_pkg;
   localparam logic [7:0] ESC_LINE_END  = 8'd0;
   localparam logic [7:0] ESC_IMAGE_END = 8'd1;
   localparam logic [7:0] ESC_DELTA     = 8'd2;
endpackage

module bitmap_rle_run_decoder_core_checker
   import brle_pkg::*;
   import brle_escape_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic [15:0] rsp_pixel_row,
   input  logic [15:0] rsp_pixel_column,
   input  logic [7:0]  rsp_pixel_count,
   input  logic [7:0]  rsp_even_index,
   input  logic [7:0]  rsp_odd_index,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          failures,
   output int          compared,
   output int          outstanding
);

   typedef enum logic [2:0] {
      AWAIT_COUNT,
      AWAIT_SECOND,
      AWAIT_DX,
      AWAIT_DY,
      IN_LITERAL,
      HALTED_ERROR
   } parse_step_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] row;
      logic [15:0] column;
      logic [7:0]  count;
      logic [7:0]  even_ix;
      logic [7:0]  odd_ix;
   } pixel_write_type;

   pixel_write_type expected_writes[$];

   coord_type      img_width;
   coord_type      img_height;
   logic           top_first;
   logic           nibble;
   parse_step_type step;
   logic [7:0]     run_len;
   coord_type      line_left;
   coord_type      col_pos;
   logic [7:0]     literal_left;
   logic           pad_due;

   initial begin
      failures    = 0;
      compared    = 0;
      outstanding = 0;
   end

   task automatic flag_mismatch(input string what);
      $display("%t mismatch: %s", $realtime, what);
      failures++;
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want)
         flag_mismatch($sformatf("descriptor %0d %s got %0d, expected %0d",
                                 compared, name, got, want));
   endtask

   function automatic void push_status(input logic [1:0] code);
      pixel_write_type w;
      w = '0;
      w.status = code;
      expected_writes.push_back(w);
   endfunction

   function automatic void push_pixels(input int unsigned n, input logic [7:0] b);
      pixel_write_type w;
      w = '0;
      w.status  = STATUS_PIXELS;
      w.row     = top_first ? coord_type'(img_height - line_left)
                            : coord_type'(line_left - 1);
      w.column  = col_pos;
      w.count   = n[7:0];
      w.even_ix = nibble ? {4'h0, b[7:4]} : b;
      w.odd_ix  = nibble ? {4'h0, b[3:0]} : b;
      col_pos   = coord_type'(col_pos + n);
      expected_writes.push_back(w);
   endfunction

   function automatic void apply_setting(input logic [1:0] index, input logic [15:0] value);
      case (index)
         CSR_IMAGE_WIDTH: img_width = value;
         CSR_IMAGE_HEIGHT: begin
            img_height = value;
            line_left  = value;
            col_pos    = '0;
         end
         CSR_TOP_DOWN: top_first = value[0];
         CSR_NIBBLE_MODE: nibble = value[0];
         default: ;
      endcase
   endfunction

   // Advance the parser by one stream byte and queue the descriptor it causes.
   function automatic void decode_byte(input logic [7:0] b);
      int unsigned n;
      if (step == HALTED_ERROR || line_left == 0) return;
      case (step)
         AWAIT_COUNT: begin
            run_len = b;
            step    = AWAIT_SECOND;
         end
         AWAIT_SECOND: begin
            if (run_len != 0) begin
               step = AWAIT_COUNT;
               n = (col_pos < img_width) ? img_width - col_pos : 0;
               if (run_len < n) n = run_len;
               if (n != 0) push_pixels(n, b);
            end else if (b == ESC_LINE_END) begin
               line_left = line_left - 1'b1;
               col_pos   = '0;
               step      = AWAIT_COUNT;
               if (line_left == 0) push_status(STATUS_DONE);
            end else if (b == ESC_IMAGE_END) begin
               line_left = '0;
               col_pos   = '0;
               step      = AWAIT_COUNT;
               push_status(STATUS_DONE);
            end else if (b == ESC_DELTA) begin
               step = AWAIT_DX;
            end else begin
               // trim by width parity first, then give up if still too long
               n = b;
               if (col_pos + n > img_width) begin
                  n -= img_width[0];
                  if (col_pos + n > img_width) begin
                     step = HALTED_ERROR;
                     push_status(STATUS_ERROR);
                     return;
                  end
               end
               literal_left = n[7:0];
               pad_due = nibble ? (((n - 1) & 2) == 0) : (((n - 1) & 1) == 0);
               step = IN_LITERAL;
            end
         end
         AWAIT_DX: begin
            n = col_pos + b;
            col_pos = (n > img_width) ? img_width : n[15:0];
            step = AWAIT_DY;
         end
         AWAIT_DY: begin
            step = AWAIT_COUNT;
            line_left = line_left - ((b < line_left) ? coord_type'(b) : line_left);
            if (line_left == 0) push_status(STATUS_DONE);
         end
         IN_LITERAL: begin
            if (literal_left == 0) begin
               // drop the pad byte
               pad_due = 1'b0;
               step    = AWAIT_COUNT;
            end else begin
               n = nibble ? ((literal_left < 2) ? literal_left : 2) : 1;
               literal_left = literal_left - n[7:0];
               if (literal_left == 0 && !pad_due) step = AWAIT_COUNT;
               push_pixels(n, b);
            end
         end
         default: step = HALTED_ERROR;
      endcase
   endfunction

   task automatic check_result();
      pixel_write_type want;
      if (expected_writes.size() == 0) begin
         flag_mismatch($sformatf("descriptor with status %0d while none expected",
                                 rsp_status));
         return;
      end
      want = expected_writes.pop_front();
      compare_field("status", 16'(rsp_status), 16'(want.status));
      compare_field("pixel_row", rsp_pixel_row, want.row);
      compare_field("pixel_column", rsp_pixel_column, want.column);
      compare_field("pixel_count", 16'(rsp_pixel_count), 16'(want.count));
      compare_field("even_index", 16'(rsp_even_index), 16'(want.even_ix));
      compare_field("odd_index", 16'(rsp_odd_index), 16'(want.odd_ix));
      compared++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         img_width    = '0;
         img_height   = '0;
         top_first    = 1'b0;
         nibble       = 1'b0;
         step         = AWAIT_COUNT;
         run_len      = '0;
         line_left    = '0;
         col_pos      = '0;
         literal_left = '0;
         pad_due      = 1'b0;
         expected_writes.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_result();
         if (csr_valid && csr_ready) apply_setting(csr_index, csr_wdata);
         if (req_valid && req_ready) decode_byte(req_data_byte);
      end
      outstanding <= expected_writes.size();
   end

endmodule

// ===== bench/bitmap_rle_run_decoder_core_test.sv =====
// Stimulus and verdict for the run-length bitmap decoder core.
`timescale 1ns / 100ps

module bitmap_rle_run_decoder_core_test;
   import brle_pkg::*;
   import brle_escape_pkg::*;

   localparam int unsigned ITEM_TARGET = 1750;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_pixel_row;
   logic [15:0] rsp_pixel_column;
   logic [7:0]  rsp_pixel_count;
   logic [7:0]  rsp_even_index;
   logic [7:0]  rsp_odd_index;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_IMAGE_WIDTH;
   logic [15:0] csr_wdata = 16'h0000;

   int failures;
   int compared;
   int outstanding;

   // stream position as the encoder sees it
   int unsigned image_w;
   int unsigned col;
   int unsigned lines;
   bit          nib;
   int unsigned bytes_sent;
   int unsigned images;
   int unsigned gap_max = 8;

   bitmap_rle_run_decoder_core dut (.*);

   bitmap_rle_run_decoder_core_checker result_check (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #1_000_000;
      $display("[bitmap_rle_run_decoder_core] ERROR");
      $finish;
   end

   task automatic send_byte(input logic [7:0] value);
      int unsigned gap;
      gap = $urandom_range(gap_max, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= value;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Hold until every expected descriptor is in, then let the pipe drain.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic configure(input int unsigned wd, input int unsigned ht,
                            input bit td, input bit nb);
      settle();
      write_csr(CSR_IMAGE_WIDTH, wd[15:0]);
      write_csr(CSR_IMAGE_HEIGHT, ht[15:0]);
      write_csr(CSR_TOP_DOWN, {15'd0, td});
      write_csr(CSR_NIBBLE_MODE, {15'd0, nb});
      csr_valid <= 1'b0;
      image_w = wd;
      lines   = ht;
      col     = 0;
      nib     = nb;
   endtask

   task automatic encoded_run(input int unsigned cnt, input logic [7:0] value);
      send_byte(cnt[7:0]);
      send_byte(value);
      if (col < image_w) col += (cnt < image_w - col) ? cnt : image_w - col;
   endtask

   task automatic end_of_line();
      send_byte(8'h00);
      send_byte(ESC_LINE_END);
      lines--;
      col = 0;
   endtask

   task automatic end_of_image();
      send_byte(8'h00);
      send_byte(ESC_IMAGE_END);
      lines = 0;
      col   = 0;
   endtask

   task automatic jump(input int unsigned dx, input int unsigned dy);
      send_byte(8'h00);
      send_byte(ESC_DELTA);
      send_byte(dx[7:0]);
      send_byte(dy[7:0]);
      col = (col + dx > image_w) ? image_w : col + dx;
      lines -= (dy < lines) ? dy : lines;
   endtask

   // Literal run that fits the line, possibly only after the parity trim.
   task automatic literal_run(input int unsigned len);
      int unsigned n;
      int unsigned nbytes;
      bit          pad;
      n = len;
      if (col + n > image_w) n -= image_w & 1;
      nbytes = nib ? (n + 1) / 2 : n;
      pad = nib ? (n % 4 == 1 || n % 4 == 2) : (n % 2 == 1);
      send_byte(8'h00);
      send_byte(len[7:0]);
      repeat (nbytes) send_byte(8'($urandom));
      if (pad) send_byte(8'($urandom));
      col += n;
   endtask

   function automatic int unsigned literal_room();
      return image_w - col + (image_w & 1);
   endfunction

   initial begin : rsp_side
      int unsigned stall;
      @(negedge reset);
      forever begin
         stall = $urandom_range(gap_max, 0);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   initial begin : stimulus
      int unsigned wd;
      int unsigned ht;
      int unsigned ops;
      int unsigned pick;
      int unsigned room;
      int unsigned guard;
      image_w    = 0;
      col        = 0;
      lines      = 0;
      nib        = 1'b0;
      bytes_sent = 0;
      images     = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // halted after reset: zero height
      send_byte(8'hFF);
      send_byte(8'h00);

      configure(10, 3, 1'b0, 1'b0);
      encoded_run(4, 8'hA5);
      encoded_run(255, 8'h5A);   // clipped to the line end
      encoded_run(1, 8'hFF);     // already at the line end, no write
      end_of_line();
      literal_run(3);            // odd length, padded
      jump(255, 255);            // column clamped, image finished

      configure(7, 16'hFFFF, 1'b1, 1'b1);
      literal_run(8);            // trimmed by odd width
      end_of_image();
      send_byte(8'h42);          // ignored at line zero

      while (bytes_sent < ITEM_TARGET) begin
         case (images % 8)
            0: wd = 0;
            1: wd = 16'hFFFF;
            2: wd = 1;
            3: wd = $urandom_range(300, 0);
            default: wd = $urandom_range(40, 2);
         endcase
         case (images % 5)
            0: ht = 16'hFFFF;
            1: ht = 1;
            default: ht = $urandom_range(6, 2);
         endcase
         configure(wd, ht, $urandom_range(1, 0), $urandom_range(1, 0));
         gap_max = ($urandom_range(3, 0) == 0) ? 0 : 8;
         ops = $urandom_range(30, 4);
         while (lines != 0) begin
            if (ops == 0) begin
               end_of_image();
            end else begin
               ops--;
               pick = $urandom_range(99, 0);
               room = literal_room();
               if (pick < 40) begin
                  encoded_run(($urandom_range(3, 0) == 0) ? $urandom_range(255, 1)
                                                          : $urandom_range(8, 1),
                              8'($urandom));
               end else if (pick < 72 && room >= 3) begin
                  if (room > (($urandom_range(7, 0) == 0) ? 255 : 20))
                     room = ($urandom_range(7, 0) == 0) ? 255 : 20;
                  literal_run(($urandom_range(3, 0) == 0) ? room
                                                          : $urandom_range(room, 3));
               end else if (pick < 88) begin
                  end_of_line();
               end else if (pick < 96) begin
                  jump(($urandom_range(3, 0) == 0) ? $urandom_range(255, 0)
                                                   : $urandom_range(6, 0),
                       ($urandom_range(3, 0) == 0) ? $urandom_range(255, 0)
                                                   : $urandom_range(1, 0));
               end else begin
                  end_of_image();
               end
            end
         end
         repeat ($urandom_range(2, 0)) send_byte(8'($urandom));
         images++;
      end

      // a literal run too long even after the trim halts the block for good
      gap_max = 8;
      configure(5, 2, $urandom_range(1, 0), $urandom_range(1, 0));
      send_byte(8'h00);
      send_byte(8'd10);
      repeat (3) send_byte(8'($urandom));
      configure(5, 2, 1'b0, 1'b0);
      encoded_run(3, 8'h77);

      req_valid <= 1'b0;
      guard = 0;
      do begin
         @(posedge clock);
         guard++;
      end while (outstanding != 0 && guard < 4000);
      repeat (8) @(posedge clock);

      $display("Covered %0d stream bytes in %0d random images, both run codings,",
               bytes_sent, images);
      $display("widths 0 to 65535 and heights 1 to 65535; %0d descriptors compared.",
               compared);
      if (outstanding != 0)
         $display("%0d expected descriptors never arrived", outstanding);
      if (failures == 0 && outstanding == 0) begin
         $display("[bitmap_rle_run_decoder_core] OK");
      end else begin
         $display("[bitmap_rle_run_decoder_core] ERROR");
      end
      $finish;
   end

endmodule
